// ===== rtl/eprc_pkg.sv =====
`default_nettype none

package eprc_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned POS_W        = 32;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned DIV_CNT_W    = $clog2(RATE_W);

  // Dividend of the rate division; also the saturated rate at zero gap.
  localparam logic [RATE_W-1:0] RATE_NUM = RATE_W'(1000000);

  typedef struct packed {
    logic            channel;
    logic            direction;
    logic [TS_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic                    channel_out;
    logic signed [POS_W-1:0] position;
    logic [RATE_W-1:0]       rate_hz;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // take the input item, update channel state, start divide
    logic step;     // one restoring-divide iteration
    logic publish;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ch_ok;    // input channel is below CHANNELS
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/encoder_position_and_rate_counter.sv =====
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       input      in_valid_i/in_stall_o    in_item_i  (channel, direction, timestamp_us)
// out      output     out_valid_o/out_stall_i  out_item_o (channel_out, position, rate_hz)
//
// Sequence: each item is loaded, run through 20 restoring-divide steps, then published;
//   the bit-serial 1000000 / gap divider sets the pace; no new item is taken until the last is published.
// Reset: rst_ni clears position and last edge time of every channel to zero.
// Stalls: the finished result sits in an output register, so a new item is taken
//   while it waits; a second result waits in the hold state until the register frees.
// Items for a channel not below CHANNELS are taken and dropped with no result.

module encoder_position_and_rate_counter #(
  parameter int unsigned CHANNELS = eprc_pkg::CHANNELS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire eprc_pkg::in_item_t in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output eprc_pkg::out_item_t  out_item_o
);
  import eprc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: idle -> divide steps -> hold until the output register frees.
  eprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Per-channel position and last edge time, gap subtract, divider, output register.
  eprc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/eprc_datapath.sv =====
`default_nettype none

module eprc_datapath #(
  parameter int unsigned CHANNELS = eprc_pkg::CHANNELS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire eprc_pkg::in_item_t  in_item_i,
  input  wire eprc_pkg::cmd_t      cmd_i,
  output eprc_pkg::sts_t           sts_o,
  output eprc_pkg::out_item_t      out_item_o
);
  import eprc_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [POS_W-1:0]  pos_q  [CHANNELS];
  logic [TS_W-1:0]   last_q [CHANNELS];

  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  pos_new;
  logic [TS_W-1:0]   gap;

  // Divide working registers and latched result fields.
  logic              ch_q;
  logic [POS_W-1:0]  res_pos_q;
  logic [TS_W-1:0]   gap_q;
  logic              gap_zero_q;
  logic [TS_W-1:0]   rem_q, rem_d;
  logic [RATE_W-1:0] quo_q, quo_d;
  logic [TS_W:0]     trial;
  out_item_t         out_q;

  assign idx         = IDX_W'(in_item_i.channel);
  assign sts_o.ch_ok = 32'(in_item_i.channel) < CHANNELS;

  // +1 when direction is high, -1 otherwise.
  assign pos_new = pos_q[idx] + {{(POS_W-1){~in_item_i.direction}}, 1'b1};
  assign gap     = in_item_i.timestamp_us - last_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]  <= '0;
        last_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      pos_q[idx]  <= pos_new;
      last_q[idx] <= in_item_i.timestamp_us;
    end
  end

  // Restoring divide: shift one dividend bit into the remainder per step.
  always_comb begin
    trial = {rem_q, quo_q[RATE_W-1]};
    if (trial >= {1'b0, gap_q}) begin
      rem_d = TS_W'(trial - {1'b0, gap_q});
      quo_d = {quo_q[RATE_W-2:0], 1'b1};
    end else begin
      rem_d = trial[TS_W-1:0];
      quo_d = {quo_q[RATE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q       <= in_item_i.channel;
      res_pos_q  <= pos_new;
      gap_q      <= gap;
      gap_zero_q <= (gap == '0);
      rem_q      <= '0;
      quo_q      <= RATE_NUM;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.publish) begin
      out_q.channel_out <= ch_q;
      out_q.position    <= res_pos_q;
      out_q.rate_hz     <= gap_zero_q ? RATE_NUM : quo_q;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/eprc_ctrl.sv =====
`default_nettype none

module eprc_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire eprc_pkg::sts_t sts_i,
  output eprc_pkg::cmd_t   cmd_o
);
  import eprc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 out_valid_q;
  logic                 slot_free;

  assign slot_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;

  // Items for a channel that does not exist are taken and dropped.
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i && sts_i.ch_ok;
  assign cmd_o.step    = (state_q == S_DIV);
  assign cmd_o.publish = (state_q == S_HOLD) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (cmd_o.load) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(RATE_W - 1)) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // Each divide runs its full step count before the result is held.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) && $past(state_q == S_DIV) |->
      $past(cnt_q == DIV_CNT_W'(RATE_W - 1)))
    else $error("divide ended early");

  // Publishing always yields a valid result next cycle.
  a_pub_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not presented");

  // No new item is loaded while a divide is in flight.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DIV) && !cmd_o.load)
    else $error("load outside idle");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import eprc_pkg::*;

  // Run limits. The limit leaves room for the divide of every edge, receiver
  // stalls, sender gaps and the long hold-off many times over.
  localparam int unsigned RANDOM_EDGES = 1150;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 37;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  encoder_position_and_rate_counter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // 8 ns clock, first rising edge at 4 ns.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Edge-counter model: per-channel position and last edge time.
  // ---------------------------------------------------------------------
  logic signed [POS_W-1:0] chan_position [CHANNELS_DEF];
  logic [TS_W-1:0]         chan_last_ts  [CHANNELS_DEF];

  // Results still owed by the block, oldest first.
  out_item_t pending_results [$];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;

  // 1000000 / gap, saturating when the gap is zero.
  function automatic logic [RATE_W-1:0] edge_rate_hz(input logic [TS_W-1:0] gap);
    logic [TS_W-1:0] quot;
    if (gap == '0) return RATE_NUM;
    quot = TS_W'(RATE_NUM) / gap;
    return quot[RATE_W-1:0];
  endfunction

  // Apply one edge to the channel state and return the result it yields.
  function automatic out_item_t advance_channel(input in_item_t edge_in);
    out_item_t       res;
    logic [TS_W-1:0] gap;
    if (edge_in.direction)
      chan_position[edge_in.channel] = chan_position[edge_in.channel] + 1;
    else
      chan_position[edge_in.channel] = chan_position[edge_in.channel] - 1;
    // modular difference handles timer wrap
    gap = edge_in.timestamp_us - chan_last_ts[edge_in.channel];
    chan_last_ts[edge_in.channel] = edge_in.timestamp_us;
    res.channel_out = edge_in.channel;
    res.position    = chan_position[edge_in.channel];
    res.rate_hz     = edge_rate_hz(gap);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Directed edges. Rows with known=1 carry a hand-computed result; the
  // rest are checked against the model.
  // ---------------------------------------------------------------------
  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t res;
  } edge_row_t;

  localparam int unsigned DIRECTED_ROWS = 16;
  localparam edge_row_t EDGE_ROWS [DIRECTED_ROWS] = '{
    // first edge after reset, zero gap from the reset time -> saturated
    '{'{1'b0, 1'b1, 32'd0},          1'b1, '{1'b0,  32'sd1, RATE_NUM}},
    // equal timestamps -> saturated
    '{'{1'b0, 1'b1, 32'd0},          1'b1, '{1'b0,  32'sd2, RATE_NUM}},
    // gap of one microsecond
    '{'{1'b0, 1'b0, 32'd1},          1'b1, '{1'b0,  32'sd1, RATE_NUM}},
    // gap of exactly one second -> 1 Hz
    '{'{1'b0, 1'b0, 32'd1000001},    1'b1, '{1'b0,  32'sd0, 20'd1}},
    // just over one second -> 0 Hz, position goes negative
    '{'{1'b0, 1'b0, 32'd2000002},    1'b1, '{1'b0, -32'sd1, 20'd0}},
    // timestamp at its top value, huge gap
    '{'{1'b0, 1'b0, 32'hFFFF_FFFF},  1'b1, '{1'b0, -32'sd2, 20'd0}},
    // timer wrap: true gap is 2 us
    '{'{1'b0, 1'b1, 32'h0000_0001},  1'b1, '{1'b0, -32'sd1, 20'd500000}},
    // first edge on channel 1, measured from time 0
    '{'{1'b1, 1'b0, 32'd3},          1'b1, '{1'b1, -32'sd1, 20'd333333}},
    '{'{1'b1, 1'b1, 32'd1003},       1'b1, '{1'b1,  32'sd0, 20'd1000}},
    '{'{1'b1, 1'b1, 32'h8000_0000},  1'b0, '0},
    '{'{1'b0, 1'b1, 32'h5555_5555},  1'b0, '0},
    '{'{1'b1, 1'b0, 32'hAAAA_AAAA},  1'b0, '0},
    '{'{1'b1, 1'b0, 32'hAAAA_AAAA},  1'b0, '0},
    '{'{1'b0, 1'b1, 32'h5564_9794},  1'b0, '0},
    '{'{1'b1, 1'b1, 32'hFFFF_FFFE},  1'b0, '0},
    '{'{1'b1, 1'b1, 32'h0000_0005},  1'b0, '0}
  };

  // Next timestamp for a channel: mostly realistic gaps, some boundary
  // gaps around one second, some fully random jumps.
  function automatic logic [TS_W-1:0] next_stamp(input logic chan);
    int unsigned     pick;
    logic [TS_W-1:0] gap;
    pick = $urandom_range(99);
    if (pick < 5)       gap = '0;
    else if (pick < 30) gap = $urandom_range(1, 16);
    else if (pick < 55) gap = $urandom_range(17, 5000);
    else if (pick < 75) gap = $urandom_range(5001, 1000000);
    else if (pick < 85) gap = 32'd999999 + $urandom_range(0, 2);
    else                gap = $urandom();
    return chan_last_ts[chan] + gap;
  endfunction

  // Offer one edge and hold it until taken. Acceptance is decided at the
  // falling edge, where valid and stall are both settled for the coming
  // rising edge.
  task automatic offer_edge(input in_item_t edge_in, input logic known,
                            input out_item_t known_res);
    out_item_t predicted;
    bit        taken;
    in_item_i  <= edge_in;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    predicted = advance_channel(edge_in);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  // Random sender gaps; valid is only lowered when a gap really happens.
  task automatic sender_gap(input bit allowed);
    while (allowed && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: reset, directed table, random edges, drain, verdict.
  // ---------------------------------------------------------------------
  initial begin
    in_item_t edge_in;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      chan_position[c] = '0;
      chan_last_ts[c]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      sender_gap(1'b1);
      offer_edge(EDGE_ROWS[r].stim, EDGE_ROWS[r].known, EDGE_ROWS[r].res);
    end

    for (int k = 0; k < RANDOM_EDGES; k++) begin
      // pause once until the block has delivered everything owed
      if (k == 900) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      // a stretch of back-to-back offers
      sender_gap(!(k >= 400 && k < 600));
      edge_in.channel      = 1'($urandom_range(1));
      edge_in.direction    = 1'($urandom_range(1));
      edge_in.timestamp_us = next_stamp(edge_in.channel);
      offer_edge(edge_in, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // catch any stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Compare one taken result with the oldest owed one.
  task automatic check_edge_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing owed: ch %0d pos %0d rate %0d",
               $time, got.channel_out, got.position, got.rate_hz);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.channel_out !== want.channel_out) begin
      $display("%0t: channel_out expected %0d actual %0d",
               $time, want.channel_out, got.channel_out);
      mismatches++;
    end
    if (got.position !== want.position) begin
      $display("%0t: position expected %0d actual %0d",
               $time, want.position, got.position);
      mismatches++;
    end
    if (got.rate_hz !== want.rate_hz) begin
      $display("%0t: rate_hz expected %0d actual %0d",
               $time, want.rate_hz, got.rate_hz);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: checks taken results at the falling edge, sets stall for the
  // next cycle at the rising edge. One long hold-off fills the block so
  // that it stalls its input; a window of results is taken without stalls.
  // ---------------------------------------------------------------------
  initial begin
    bit          hold_done;
    int unsigned hold_left;
    hold_done   = 1'b0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        check_edge_result(out_item_o);
        results_seen++;
      end
      @(posedge clk_i);
      if (!hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (results_seen >= 400 && results_seen < 600) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
